// ===== sv/mixed_type_numeric_compare_assert.svh =====
// Assertion macros for the compare unit
`ifndef MIXED_TYPE_NUMERIC_COMPARE_ASSERT_SVH
`define MIXED_TYPE_NUMERIC_COMPARE_ASSERT_SVH
`ifndef SYNTHESIS
`define MTNC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTNC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MTNC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MTNC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/mtnc_pkg.sv =====
`default_nettype none
package mtnc_pkg;
    typedef enum logic [2:0] {
        TAG_I8  = 3'd0,
        TAG_I16 = 3'd1,
        TAG_I32 = 3'd2,
        TAG_I64 = 3'd3,
        TAG_F32 = 3'd4,
        TAG_F64 = 3'd5,
        TAG_NON = 3'd6,
        TAG_BAD = 3'd7
    } tag_t;

    localparam logic CMD_LT = 1'b0;
    localparam logic CMD_LE = 1'b1;

    // Operand normalized to sign plus exponent plus 64-bit significand.
    typedef struct packed {
        logic        is_nan;
        logic        is_zero;
        logic        neg;
        logic [12:0] expo;
        logic [63:0] mant;
    } num_t;
endpackage
`default_nettype wire

// ===== sv/mixed_type_numeric_compare.sv =====
// Throughput: one compare per cycle; start is registered through v1_reg to v4_reg, which drives strobe.
// busy stays low; the receiver cannot stall, so a beat never waits.
// Stages: decode, leading-one count, normalize and round, magnitude compare.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none
`include "mixed_type_numeric_compare_assert.svh"
module mixed_type_numeric_compare
    import mtnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [2:0]  left_type,
    input  wire logic [63:0] left_bits,
    input  wire logic [2:0]  right_type,
    input  wire logic [63:0] right_bits,
    output logic             strobe,
    output logic             is_true
);
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        le1_reg, le2_reg, le3_reg;
    logic        bad1_reg, bad2_reg, bad3_reg;
    logic        ii1_reg;
    logic [63:0] li1_reg, ri1_reg;
    logic        lf1_reg, rf1_reg;
    logic        lk1_reg, rk1_reg;
    logic [63:0] lb1_reg, rb1_reg;
    logic        p24_1_reg;
    logic        res4_reg;

    // stage 2 decoded pair, not yet normalized
    num_t        ln2_reg, rn2_reg;
    logic        ilt2_reg, ieq2_reg, ii2_reg, p24_2_reg;
    logic        lf2_reg, rf2_reg;
    logic [6:0]  lsh2_reg, rsh2_reg;
    num_t        ln3_reg, rn3_reg;
    logic        ilt3_reg, ieq3_reg, ii3_reg;

    logic        accept;
    assign accept = start && !busy;
    assign busy = 1'b0;

    function automatic logic [63:0] sext(input logic [2:0] t, input logic [63:0] b);
        logic [63:0] r;
        case (t)
            TAG_I8:  r = {{56{b[7]}}, b[7:0]};
            TAG_I16: r = {{48{b[15]}}, b[15:0]};
            TAG_I32: r = {{32{b[31]}}, b[31:0]};
            default: r = b;
        endcase
        return r;
    endfunction

    // Float decode: unbiased-exponent offset so that all values share one scale.
    // Value = mant * 2^(expo - 1150); mant has its leading one at bit 63 for normal inputs, not for subnormals or zero.
    function automatic num_t fdec(input logic dbl, input logic [63:0] b);
        num_t r;
        logic [10:0] e;
        logic [51:0] f;
        r = '0;
        if (dbl)
        begin
            e = b[62:52];
            f = b[51:0];
            r.neg = b[63];
        end
        else
        begin
            e = {3'b000, b[30:23]};
            f = {b[22:0], 29'd0};
            r.neg = b[31];
        end
        if (dbl)
        begin
            r.is_nan  = (e == 11'h7FF) && (f != 0);
            r.is_zero = (e == 0) && (f == 0);
            r.mant    = (e == 0) ? {1'b0, f, 11'd0} : {1'b1, f, 11'd0};
            r.expo    = (e == 0) ? 13'd65 : {2'b00, e} + 13'd64;
        end
        else
        begin
            r.is_nan  = (e[7:0] == 8'hFF) && (f != 0);
            r.is_zero = (e == 0) && (f == 0);
            r.mant    = (e == 0) ? {1'b0, f, 11'd0} : {1'b1, f, 11'd0};
            if (e[7:0] == 8'hFF)
                r.expo = 13'd2111;
            else
                r.expo = (e == 0) ? 13'd961 : 13'd960 + {2'b00, e};
        end
        return r;
    endfunction

    function automatic logic [6:0] lzc(input logic [63:0] m);
        logic [6:0] n;
        logic       hit;
        n = 7'd64;
        hit = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!hit && m[i])
            begin
                n = 7'(63 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Round magnitude (already shifted so top bit is 63) to prec bits, RNE.
    function automatic num_t rnd(input num_t x, input logic p24);
        num_t        r;
        logic [64:0] s;
        logic [63:0] keepmask;
        logic        g, st, lsb;
        r = x;
        if (p24)
        begin
            lsb = x.mant[40];
            g   = x.mant[39];
            st  = |x.mant[38:0];
            keepmask = {{24{1'b1}}, 40'd0};
            s = {1'b0, x.mant & keepmask} + ((g && (st || lsb)) ? 65'h1_0000_0000_00 : 65'd0);
        end
        else
        begin
            lsb = x.mant[11];
            g   = x.mant[10];
            st  = |x.mant[9:0];
            keepmask = {{53{1'b1}}, 11'd0};
            s = {1'b0, x.mant & keepmask} + ((g && (st || lsb)) ? 65'h800 : 65'd0);
        end
        if (s[64])
        begin
            r.mant = {1'b1, 63'd0};
            r.expo = x.expo + 13'd1;
        end
        else
            r.mant = s[63:0];
        return r;
    endfunction

    // stage 1: decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        le1_reg   <= cmd;
        bad1_reg  <= (left_type > TAG_F64) || (right_type > TAG_F64);
        ii1_reg   <= (left_type <= TAG_I64) && (right_type <= TAG_I64);
        li1_reg   <= sext(left_type, left_bits);
        ri1_reg   <= sext(right_type, right_bits);
        lf1_reg   <= left_type > TAG_I64;
        rf1_reg   <= right_type > TAG_I64;
        lb1_reg   <= left_bits;
        rb1_reg   <= right_bits;
        lk1_reg   <= left_type == TAG_F64;
        rk1_reg   <= right_type == TAG_F64;
        p24_1_reg <= (left_type == TAG_F32) || (right_type == TAG_F32);
    end

    // stage 2: integer to magnitude form, float decode, leading-zero count, integer compare
    num_t        lnx, rnx;
    logic [63:0] lmag, rmag;
    always_comb
    begin
        lmag = li1_reg[63] ? (~li1_reg + 64'd1) : li1_reg;
        rmag = ri1_reg[63] ? (~ri1_reg + 64'd1) : ri1_reg;
        if (lf1_reg)
            lnx = fdec(lk1_reg, lb1_reg);
        else
        begin
            lnx = '0;
            lnx.neg = li1_reg[63];
            lnx.is_zero = (li1_reg == 0);
            lnx.mant = lmag;
            lnx.expo = 13'd1150;
        end
        if (rf1_reg)
            rnx = fdec(rk1_reg, rb1_reg);
        else
        begin
            rnx = '0;
            rnx.neg = ri1_reg[63];
            rnx.is_zero = (ri1_reg == 0);
            rnx.mant = rmag;
            rnx.expo = 13'd1150;
        end
    end

    always_ff @(posedge clk)
    begin
        le2_reg   <= le1_reg;
        bad2_reg  <= bad1_reg;
        ii2_reg   <= ii1_reg;
        p24_2_reg <= p24_1_reg;
        lf2_reg   <= lf1_reg;
        rf2_reg   <= rf1_reg;
        ln2_reg   <= lnx;
        rn2_reg   <= rnx;
        lsh2_reg  <= lzc(lnx.mant);
        rsh2_reg  <= lzc(rnx.mant);
        ilt2_reg  <= $signed(li1_reg) < $signed(ri1_reg);
        ieq2_reg  <= li1_reg == ri1_reg;
    end

    // stage 3: normalize, then round integers to the float format
    num_t ln_n, rn_n;
    always_comb
    begin
        ln_n = ln2_reg;
        rn_n = rn2_reg;
        if (!ln2_reg.is_zero)
        begin
            ln_n.mant = ln2_reg.mant << lsh2_reg[5:0];
            ln_n.expo = ln2_reg.expo - {6'd0, lsh2_reg};
        end
        if (!rn2_reg.is_zero)
        begin
            rn_n.mant = rn2_reg.mant << rsh2_reg[5:0];
            rn_n.expo = rn2_reg.expo - {6'd0, rsh2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        le3_reg  <= le2_reg;
        bad3_reg <= bad2_reg;
        ii3_reg  <= ii2_reg;
        ilt3_reg <= ilt2_reg;
        ieq3_reg <= ieq2_reg;
        ln3_reg  <= lf2_reg ? ln_n : rnd(ln_n, p24_2_reg);
        rn3_reg  <= rf2_reg ? rn_n : rnd(rn_n, p24_2_reg);
    end

    // stage 4: sign-magnitude compare
    logic mlt, meq, flt, feq, res;
    always_comb
    begin
        meq = (ln3_reg.expo == rn3_reg.expo) && (ln3_reg.mant == rn3_reg.mant);
        mlt = (ln3_reg.expo < rn3_reg.expo) ||
              ((ln3_reg.expo == rn3_reg.expo) && (ln3_reg.mant < rn3_reg.mant));
        if (ln3_reg.is_zero && rn3_reg.is_zero)
        begin
            feq = 1'b1;
            flt = 1'b0;
        end
        else if (ln3_reg.is_zero)
        begin
            feq = 1'b0;
            flt = !rn3_reg.neg;
        end
        else if (rn3_reg.is_zero)
        begin
            feq = 1'b0;
            flt = ln3_reg.neg;
        end
        else if (ln3_reg.neg != rn3_reg.neg)
        begin
            feq = 1'b0;
            flt = ln3_reg.neg;
        end
        else
        begin
            feq = meq;
            flt = ln3_reg.neg ? (!mlt && !meq) : mlt;
        end
        if (bad3_reg)
            res = 1'b0;
        else if (ii3_reg)
            res = ilt3_reg || (le3_reg == CMD_LE && ieq3_reg);
        else if (ln3_reg.is_nan || rn3_reg.is_nan)
            res = 1'b0;
        else
            res = flt || (le3_reg == CMD_LE && feq);
    end

    always_ff @(posedge clk)
    begin
        res4_reg <= res;
    end

    assign strobe  = v4_reg;
    assign is_true = res4_reg;

    `MTNC_ASSERT_IMPL(a_lat, clk, rst_n, accept |-> ##4 strobe, "strobe latency broken")
    `MTNC_ASSERT_IMPL(a_nostray, clk, rst_n, strobe |-> $past(accept, 4), "stray strobe")
    `MTNC_ASSERT_NEVER(a_busy, clk, rst_n, busy, "busy raised")
endmodule
`default_nettype wire
